[src/pep_pkg.sv]
// package of types, widths and constants for the polar echo to pixel converter
`timescale 1ns / 1ps
`default_nettype none

package pep_pkg;

    // field widths
    localparam int ANGLE_W  = 14;
    localparam int RADIAL_W = 10;
    localparam int ECHO_W   = 8;
    localparam int RAD_W    = 11;
    localparam int PIX_W    = 11;
    localparam int INDEX_W  = 22;

    // fixed design constants
    localparam int MAX_RADIUS     = 1024;
    localparam int ANGLE_STEPS    = 8196;
    localparam int TRIG_FRAC_BITS = 15;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1024);

    // signed sine and cosine width
    localparam int TRIG_W = TRIG_FRAC_BITS + 3;

    // angle to phase: p = a * STEP_Q + floor(a * STEP_R / ANGLE_STEPS)
    localparam int ANGLE_LOG = $clog2(ANGLE_STEPS);
    localparam int NUM_W     = ANGLE_W + ANGLE_LOG;
    localparam int RECIP_W   = NUM_W - ANGLE_LOG + 1;
    localparam logic [31:0]          STEP_Q     = 32'((64'd1 << 32) / ANGLE_STEPS);
    localparam logic [ANGLE_LOG-1:0] STEP_R     = ANGLE_LOG'((64'd1 << 32) % ANGLE_STEPS);
    localparam logic [RECIP_W-1:0]   STEP_RECIP = RECIP_W'((64'd1 << NUM_W) / ANGLE_STEPS);

    // q30 sine series
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam int HORNER_TERMS = 6;

    // pipeline depths
    localparam int PHASE_STAGES = 4;
    localparam int SINE_STAGES  = 5 + 3 * HORNER_TERMS;
    localparam int COORD_STAGES = 4;
    localparam int SIDE_STAGES  = PHASE_STAGES + SINE_STAGES;
    localparam int PIPE_STAGES  = SIDE_STAGES + COORD_STAGES;

    typedef struct packed {
        logic [ANGLE_W-1:0]  spoke_angle;
        logic [RADIAL_W-1:0] radial_index;
        logic [ECHO_W-1:0]   echo_value;
    } pep_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [INDEX_W-1:0] pixel_index;
        logic [ECHO_W-1:0]  intensity;
    } pep_out_t;

endpackage

`default_nettype wire

[src/pep_phase.sv]
// angle reduction and conversion of the spoke angle to a 32-bit turn phase
`timescale 1ns / 1ps
`default_nettype none

module pep_phase (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [pep_pkg::ANGLE_W-1:0] spoke_angle,
    output logic [31:0]                 phase
);
    import pep_pkg::*;

    logic [ANGLE_W-1:0]       a_reg;
    logic [ANGLE_W-1:0]       a_next;
    logic [NUM_W-1:0]         n_reg;
    logic [NUM_W-1:0]         n2_reg;
    logic [31:0]              base_reg;
    logic [31:0]              base2_reg;
    logic [ANGLE_W-1:0]       q0_reg;
    logic [31:0]              phase_reg;
    logic [NUM_W+RECIP_W-1:0] mq;
    logic [NUM_W-1:0]         rem;
    logic [ANGLE_W-1:0]       q;

    // input stays below twice the step count
    always_comb begin
        if (32'(spoke_angle) >= ANGLE_STEPS) begin
            a_next = spoke_angle - ANGLE_W'(ANGLE_STEPS);
        end else begin
            a_next = spoke_angle;
        end
    end

    always_comb begin
        mq  = (NUM_W+RECIP_W)'(n_reg) * (NUM_W+RECIP_W)'(STEP_RECIP);
        rem = n2_reg - NUM_W'(32'(q0_reg) * 32'(ANGLE_STEPS));
        q   = q0_reg + ANGLE_W'(rem >= NUM_W'(ANGLE_STEPS));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= a_next;
            n_reg     <= NUM_W'(a_reg) * NUM_W'(STEP_R);
            base_reg  <= 32'(a_reg) * STEP_Q;
            q0_reg    <= mq[NUM_W +: ANGLE_W];
            n2_reg    <= n_reg;
            base2_reg <= base_reg;
            phase_reg <= base2_reg + 32'(q);
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

[src/pep_sine.sv]
// pipelined q30 taylor series sine of a 32-bit turn phase
`timescale 1ns / 1ps
`default_nettype none

module pep_sine (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [31:0]                       phase,
    output logic signed [pep_pkg::TRIG_W-1:0] trig
);
    import pep_pkg::*;

    localparam int H_ST = 3 * HORNER_TERMS;
    localparam logic [31:0] RND_HALF = 32'(1) << (29 - TRIG_FRAC_BITS);

    logic [1:0]  quad0_reg;
    logic [30:0] f0_reg;
    logic [1:0]  quad1_reg;
    logic [30:0] t1_reg;
    logic [61:0] tp;
    logic [61:0] sq;

    logic [30:0] t_h    [0:H_ST];
    logic [31:0] t2_h   [0:H_ST-3];
    logic [1:0]  quad_h [0:H_ST];
    logic [30:0] acc_h  [0:HORNER_TERMS];

    logic [61:0] fp;
    logic [31:0] s_reg;
    logic [1:0]  quadf_reg;
    logic [31:0] sr;
    logic [TRIG_FRAC_BITS+1:0] mag;
    logic signed [TRIG_W-1:0] trig_reg;

    always_comb begin
        tp = 62'(f0_reg) * 62'(HALF_PI_Q30);
        sq = 62'(t1_reg) * 62'(t1_reg);
    end

    // fold onto the first quadrant
    always_ff @(posedge aclk) begin
        if (en) begin
            quad0_reg <= phase[31:30];
            if (phase[30]) begin
                f0_reg <= Q30_ONE - {1'b0, phase[29:0]};
            end else begin
                f0_reg <= {1'b0, phase[29:0]};
            end
            quad1_reg <= quad0_reg;
            t1_reg    <= tp[60:30];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_h[0]    <= t1_reg;
            t2_h[0]   <= sq[61:30];
            quad_h[0] <= quad1_reg;
            for (int i = 0; i < H_ST; i++) begin
                t_h[i+1]    <= t_h[i];
                quad_h[i+1] <= quad_h[i];
            end
            for (int i = 0; i < H_ST - 3; i++) begin
                t2_h[i+1] <= t2_h[i];
            end
        end
    end

    assign acc_h[0] = Q30_ONE;

    // one horner term per three stages, divide by reciprocal with one correction
    genvar j;
    for (j = 0; j < HORNER_TERMS; j++) begin : g_term
        localparam logic [31:0] DIV =
            32'((2 * (HORNER_TERMS - j)) * (2 * (HORNER_TERMS - j) + 1));
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

        logic [31:0] prod_reg;
        logic [31:0] prodb_reg;
        logic [31:0] q0_reg;
        logic [30:0] acc_reg;
        logic [62:0] pa;
        logic [63:0] pb;
        logic [31:0] rem;
        logic [31:0] quot;

        always_comb begin
            pa   = 63'(t2_h[3*j]) * 63'(acc_h[j]);
            pb   = 64'(prod_reg) * 64'(RECIP);
            rem  = prodb_reg - 32'(q0_reg * DIV);
            quot = q0_reg + 32'(rem >= DIV);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg  <= pa[61:30];
                q0_reg    <= pb[63:32];
                prodb_reg <= prod_reg;
                acc_reg   <= Q30_ONE - quot[30:0];
            end
        end

        assign acc_h[j+1] = acc_reg;
    end

    always_comb begin
        fp  = 62'(t_h[H_ST]) * 62'(acc_h[HORNER_TERMS]);
        sr  = s_reg + RND_HALF;
        mag = sr[30-TRIG_FRAC_BITS +: TRIG_FRAC_BITS+2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg     <= fp[61:30];
            quadf_reg <= quad_h[H_ST];
            if (quadf_reg[1]) begin
                trig_reg <= -$signed(TRIG_W'(mag));
            end else begin
                trig_reg <= $signed(TRIG_W'(mag));
            end
        end
    end

    assign trig = trig_reg;

endmodule

`default_nettype wire

[src/pep_coord.sv]
// pixel coordinates, image bounds test and linear pixel index
`timescale 1ns / 1ps
`default_nettype none

module pep_coord (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [pep_pkg::RAD_W-1:0]          radius,
    input  logic signed [pep_pkg::TRIG_W-1:0]  cos_val,
    input  logic signed [pep_pkg::TRIG_W-1:0]  sin_val,
    input  logic [pep_pkg::RADIAL_W-1:0]       radial,
    input  logic [pep_pkg::ECHO_W-1:0]         echo,
    output logic                               keep,
    output pep_pkg::pep_out_t                  pix
);
    import pep_pkg::*;

    localparam int PROD_W = RADIAL_W + 1 + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CRD_W  = SUM_W - TRIG_FRAC_BITS + 1;
    localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

    logic [RAD_W-1:0]          c;
    logic [RAD_W:0]            w;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic [ECHO_W-1:0]         echo0_reg;
    logic signed [CRD_W-1:0]   x_reg;
    logic signed [CRD_W-1:0]   y_reg;
    logic [ECHO_W-1:0]         echo1_reg;
    logic                      keep_reg;
    logic [PIX_W-1:0]          x2_reg;
    logic [PIX_W-1:0]          y2_reg;
    logic [INDEX_W-1:0]        ymul_reg;
    logic [ECHO_W-1:0]         echo2_reg;
    pep_out_t                  pix_reg;
    logic                      x_ok;
    logic                      y_ok;

    // c + r*trig, rounded half away from zero
    function automatic logic signed [CRD_W-1:0] round_coord(
        input logic signed [PROD_W-1:0] p,
        input logic [RAD_W-1:0]         cc
    );
        logic signed [SUM_W-1:0] v;
        logic [SUM_W-1:0]        mag;
        logic [SUM_W-1:0]        sum;
        logic [SUM_W-TRIG_FRAC_BITS-1:0] rnd;
        logic                    neg;
        v   = $signed(SUM_W'({cc, {TRIG_FRAC_BITS{1'b0}}})) + SUM_W'(p);
        neg = v[SUM_W-1];
        mag = neg ? -v : v;
        sum = mag + RND_HALF;
        rnd = sum[SUM_W-1:TRIG_FRAC_BITS];
        return neg ? -$signed(CRD_W'(rnd)) : $signed(CRD_W'(rnd));
    endfunction

    always_comb begin
        if (radius > RAD_W'(MAX_RADIUS)) begin
            c = RAD_W'(MAX_RADIUS);
        end else begin
            c = radius;
        end
        w    = {c, 1'b0};
        x_ok = !x_reg[CRD_W-1] && (x_reg[CRD_W-2:0] < (CRD_W-1)'(w));
        y_ok = !y_reg[CRD_W-1] && (y_reg[CRD_W-2:0] < (CRD_W-1)'(w));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= PROD_W'($signed({1'b0, radial})) * PROD_W'(cos_val);
            py_reg    <= PROD_W'($signed({1'b0, radial})) * PROD_W'(sin_val);
            echo0_reg <= echo;

            x_reg     <= round_coord(px_reg, c);
            y_reg     <= round_coord(py_reg, c);
            echo1_reg <= echo0_reg;

            keep_reg  <= x_ok && y_ok;
            x2_reg    <= x_reg[PIX_W-1:0];
            y2_reg    <= y_reg[PIX_W-1:0];
            ymul_reg  <= INDEX_W'(y_reg[PIX_W-1:0]) * INDEX_W'(w);
            echo2_reg <= echo1_reg;

            pix_reg.pixel_x     <= x2_reg;
            pix_reg.pixel_y     <= y2_reg;
            pix_reg.pixel_index <= ymul_reg + INDEX_W'(x2_reg);
            pix_reg.intensity   <= echo2_reg;
        end
    end

    assign keep = keep_reg;
    assign pix  = pix_reg;

endmodule

`default_nettype wire

[src/polar_echo_to_pixel.sv]
// top level of the polar echo to pixel scan converter
`timescale 1ns / 1ps
`default_nettype none

// Converts one radar echo sample per clock into an image pixel. A request is
// accepted in every cycle while s_ready is high, and its result reaches the
// m_ channel through angle to phase conversion, the sine and cosine series
// (three stages for each of the six series terms), the coordinate, bounds and
// index logic, and the output register. Samples that fall outside the 2c by
// 2c image give no result. A two-entry output buffer keeps the pipeline
// moving after m_ready drops until a result has to wait in the second entry,
// so s_ready falls only when the buffer is full. The user must write the
// image radius (radius_reg) through cfg_we/cfg_wdata only while no request
// is in flight; the block does not enforce this. Above 1024 it acts as 1024.
module polar_echo_to_pixel (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  pep_pkg::pep_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output pep_pkg::pep_out_t         m_data,
    input  logic                      cfg_we,
    input  logic [pep_pkg::RAD_W-1:0] cfg_wdata
);
    import pep_pkg::*;

    logic [RAD_W-1:0]      radius_reg;
    logic                  pipe_en;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [RADIAL_W-1:0]   rad_pipe_reg  [0:SIDE_STAGES-1];
    logic [ECHO_W-1:0]     echo_pipe_reg [0:SIDE_STAGES-1];
    logic [31:0]           phase;
    logic [31:0]           cos_phase;
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
    logic                  keep;
    pep_out_t              pix_out;

    logic                  out_v_reg;
    logic                  out_v_next;
    pep_out_t              out_reg;
    pep_out_t              out_next;
    logic                  skid_v_reg;
    logic                  skid_v_next;
    pep_out_t              skid_reg;
    pep_out_t              skid_next;

    assign pipe_en   = !skid_v_reg;
    assign s_ready   = pipe_en;
    assign cos_phase = phase + QUARTER_TURN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    pep_phase u_phase (
        .aclk        (aclk),
        .en          (pipe_en),
        .spoke_angle (s_data.spoke_angle),
        .phase       (phase)
    );

    pep_sine u_sin (
        .aclk  (aclk),
        .en    (pipe_en),
        .phase (phase),
        .trig  (sin_val)
    );

    pep_sine u_cos (
        .aclk  (aclk),
        .en    (pipe_en),
        .phase (cos_phase),
        .trig  (cos_val)
    );

    pep_coord u_coord (
        .aclk    (aclk),
        .en      (pipe_en),
        .radius  (radius_reg),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .radial  (rad_pipe_reg[SIDE_STAGES-1]),
        .echo    (echo_pipe_reg[SIDE_STAGES-1]),
        .keep    (keep),
        .pix     (pix_out)
    );

    // radius and echo ride beside the trig pipeline
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rad_pipe_reg[0]  <= s_data.radial_index;
            echo_pipe_reg[0] <= s_data.echo_value;
            for (int i = 1; i < SIDE_STAGES; i++) begin
                rad_pipe_reg[i]  <= rad_pipe_reg[i-1];
                echo_pipe_reg[i] <= echo_pipe_reg[i-1];
            end
        end
    end

    // valid bits, out-of-image samples dropped at the last stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[PIPE_STAGES-2] && keep, vld_reg[PIPE_STAGES-3:0], s_valid};
        end
    end

    always_comb begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (skid_v_reg) begin
            if (!out_v_reg || m_ready) begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end
        end else if (!out_v_reg || m_ready) begin
            out_next   = pix_out;
            out_v_next = vld_reg[PIPE_STAGES-1];
        end else if (vld_reg[PIPE_STAGES-1]) begin
            skid_next   = pix_out;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

[src/pep_checker.sv]
// port level assertions for the polar echo to pixel converter and their bind
`timescale 1ns / 1ps
`default_nettype none

module pep_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input pep_pkg::pep_in_t          s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input pep_pkg::pep_out_t         m_data,
    input logic                      cfg_we,
    input logic [pep_pkg::RAD_W-1:0] cfg_wdata
);
    import pep_pkg::*;

    logic [RAD_W-1:0]   radius_reg;
    logic [RAD_W-1:0]   c;
    logic [RAD_W:0]     w;
    logic [INDEX_W-1:0] exp_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (radius_reg > RAD_W'(MAX_RADIUS)) begin
            c = RAD_W'(MAX_RADIUS);
        end else begin
            c = radius_reg;
        end
        w         = {c, 1'b0};
        exp_index = INDEX_W'(m_data.pixel_y) * INDEX_W'(w) + INDEX_W'(m_data.pixel_x);
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.pixel_x} < w) && ({1'b0, m_data.pixel_y} < w))
        else $error("pixel outside image");

    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pixel_index == exp_index)
        else $error("pixel index does not match coordinates");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind polar_echo_to_pixel pep_checker u_pep_checker (.*);

`default_nettype wire
